// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files of the ray / sphere hit block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked property, switched off while reset is asserted.
`define RSNH_ASSERT(name, ck, rn, prop) \
  name: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("rsnh assertion failed");
// Clocked property, checked during reset as well.
`define RSNH_ASSERT_ALWAYS(name, ck, prop) \
  name: assert property (@(posedge ck) prop) else $error("rsnh assertion failed");
`else
`define RSNH_ASSERT(name, ck, rn, prop)
`define RSNH_ASSERT_ALWAYS(name, ck, prop)
`endif

`endif

// ===== rtl/core/rsnh_pkg.sv =====
// Shared types, widths, codes and helpers of the ray / sphere hit block.
package rsnh_pkg;

  localparam int MAX_SPHERES_DEF = 64;
  localparam int COORD_BITS      = 32;

  localparam int CRD_W  = 32;   // coordinate, Q16.16
  localparam int RAD_W  = 31;   // radius, Q15.16 unsigned
  localparam int H_W    = 52;   // half-b and c terms, signed Q36.16
  localparam int Q_W    = 100;  // quarter discriminant, Q68.32
  localparam int S_W    = Q_W / 2;
  localparam int X_W    = 49;   // hit point before range check, signed
  localparam int DIST_W = 54;   // squared distance, Q22.32
  localparam int DIVD_W = 49;   // normal dividend |num| << 16

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_NEAR = 2'd1;
  localparam logic [1:0] OP_OCC  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ZERO_RAD = 2'd2;

  localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(64'd1000000 << 32);
  localparam logic [X_W-1:0]    AXIS_LIMIT = X_W'(64'd1000 << 16);

  localparam logic [63:0] CB_POS    = (64'd1 << (COORD_BITS - 1)) - 64'd1;
  localparam logic [63:0] NORM_POS  = (CB_POS < 64'h7FFF_FFFF) ? CB_POS : 64'h7FFF_FFFF;
  localparam logic [63:0] NORM_NEG  = NORM_POS + 64'd1;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [CRD_W-1:0] vec_a_x;
    logic signed [CRD_W-1:0] vec_a_y;
    logic signed [CRD_W-1:0] vec_a_z;
    logic signed [CRD_W-1:0] dir_x;
    logic signed [CRD_W-1:0] dir_y;
    logic signed [CRD_W-1:0] dir_z;
    logic [RAD_W-1:0]        sphere_radius;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    hit;
    logic signed [CRD_W-1:0] hit_x;
    logic signed [CRD_W-1:0] hit_y;
    logic signed [CRD_W-1:0] hit_z;
    logic signed [CRD_W-1:0] normal_x;
    logic signed [CRD_W-1:0] normal_y;
    logic signed [CRD_W-1:0] normal_z;
    logic [5:0]              sphere_id;
  } out_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic signed [CRD_W-1:0] cz;
    logic [RAD_W-1:0]        radius;
  } sphere_t;

  // Signed normal component from sign and quotient magnitude, clamped to
  // the coordinate range and then to 32 bits.
  function automatic logic [31:0] sat_norm(input logic neg, input logic [DIVD_W-1:0] m);
    logic [63:0] mm;
    logic [63:0] v;
    mm = 64'(m);
    if (neg) begin
      v = (mm > NORM_NEG) ? NORM_NEG : mm;
      v = -v;
    end else begin
      v = (mm > NORM_POS) ? NORM_POS : mm;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/rsnh_ram.sv =====
// Generic single-port-write, registered-read RAM.
module rsnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rsnh_sqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
module rsnh_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rsnh_pkg::Q_W-1:0] radicand,
  output logic                     done,
  output logic [rsnh_pkg::S_W-1:0] root
);

  localparam int QW    = rsnh_pkg::Q_W;
  localparam int SW    = rsnh_pkg::S_W;
  localparam int REM_W = SW + 1;
  localparam int CW    = $clog2(SW + 1);

  logic [QW-1:0]    rad_r;
  logic [REM_W-1:0] rem_r;
  logic [SW-1:0]    root_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             fits;

  always_comb begin
    rem2  = {rem_r, rad_r[QW-1 -: 2]};
    trial = (REM_W + 2)'({root_r, 2'b01});
    fits  = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(SW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= fits ? REM_W'(rem2 - trial) : REM_W'(rem2);
        root_r <= {root_r[SW-2:0], fits};
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/rsnh_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rsnh_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rsnh_pkg::DIVD_W-1:0] dividend,
  input  logic [rsnh_pkg::RAD_W-1:0]  divisor,
  output logic                        done,
  output logic [rsnh_pkg::DIVD_W-1:0] quotient
);

  localparam int DW = rsnh_pkg::DIVD_W;
  localparam int RW = rsnh_pkg::RAD_W;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [RW:0]   tmp;
  logic          fits;

  always_comb begin
    tmp  = {rem_r, quo_r[DW-1]};
    fits = tmp >= (RW + 1)'(dvs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? RW'(tmp - (RW + 1)'(dvs_r)) : RW'(tmp);
        quo_r <= {quo_r[DW-2:0], fits};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/ray_sphere_nearest_hit.sv =====
// Top level: sphere table in RAM, ray walk over it with a shared multiplier.
// Add: the result passes the done state to the output register; input stalled until then.
// Occlusion: per stored sphere a RAM read, an 11-step multiply sequence, test and step.
// Nearest hit: per sphere also the 50-step square root, root test and a second multiply
//   sequence; three 49-step normal divisions for the winner. One transaction at a time.
// Reset clears the sphere count and the handshakes; table contents are not cleared.
`include "assert_macros.svh"

module ray_sphere_nearest_hit #(
  parameter int MAX_SPHERES = rsnh_pkg::MAX_SPHERES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rsnh_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rsnh_pkg::out_t out_data
);

  localparam int IDX_W  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
  localparam int H_W    = rsnh_pkg::H_W;
  localparam int Q_W    = rsnh_pkg::Q_W;
  localparam int S_W    = rsnh_pkg::S_W;
  localparam int X_W    = rsnh_pkg::X_W;
  localparam int DIST_W = rsnh_pkg::DIST_W;
  localparam int DIVD_W = rsnh_pkg::DIVD_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPHERES);

  // last step index of the two multiply sequences (last step only drains)
  localparam logic [3:0] MUL1_LAST = 4'd10;
  localparam logic [3:0] MUL2_LAST = 4'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LD, S_MUL1, S_QC, S_SQ, S_TC, S_MUL2, S_CMP,
    S_NEXT, S_NRD, S_NLD, S_DST, S_DW, S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {DISC_NEG, DISC_ZERO, DISC_POS} disc_t;

  state_t state_r;

  // transaction registers
  logic [1:0]         op_r;
  logic signed [31:0] o_r [3];
  logic signed [31:0] d_r [3];
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   idx_r;

  // per-sphere datapath
  logic [31:0]           lmag_r [3];
  logic                  lneg_r [3];
  logic [30:0]           rad_r;
  logic signed [H_W-1:0] h_r;
  logic signed [H_W-1:0] cc_r;
  logic [Q_W-1:0]        hh_r;
  logic [Q_W-1:0]        q_val;
  logic [3:0]            st_r;
  logic [3:0]            pst_r;
  logic [1:0]            pax_r;
  logic                  psgn_r;
  logic [63:0]           prod_r;
  logic [31:0]           t_r;
  logic signed [X_W-1:0] x_r [3];
  logic [DIST_W-1:0]     dist_r;

  // best hit so far
  logic [DIST_W-1:0]  best_r;
  logic signed [31:0] best_x_r [3];
  logic [IDX_W-1:0]   best_idx_r;
  logic               found_r;

  // normal phase
  logic signed [31:0] sph_c_r [3];
  logic [1:0]         ax_r;
  logic               nneg_r;
  logic [31:0]        norm_r [3];

  rsnh_pkg::out_t res_r;
  rsnh_pkg::out_t add_res;
  rsnh_pkg::out_t out_data_r;
  logic           out_valid_r;

  // initial result of an accepted transaction: add status and slot, else all zero
  always_comb begin
    add_res = '0;
    if (in_data.opcode == rsnh_pkg::OP_ADD) begin
      if (in_data.sphere_radius == '0) begin
        add_res.status = rsnh_pkg::ST_ZERO_RAD;
      end else if (cnt_r >= MAX_CNT) begin
        add_res.status = rsnh_pkg::ST_FULL;
      end else begin
        add_res.sphere_id = 6'(cnt_r);
      end
    end
  end

  // ---------------- sphere table ----------------
  rsnh_pkg::sphere_t ram_wd;
  rsnh_pkg::sphere_t ram_rd;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;

  // Writes happen only on accepting an add in idle, read data is used only during a
  // ray walk, so a write and a used read never touch the table in the same cycle.
  assign ram_we = (state_r == S_IDLE) && in_valid && (in_data.opcode == rsnh_pkg::OP_ADD) &&
                  (in_data.sphere_radius != '0) && (cnt_r < MAX_CNT);
  assign ram_wd = '{cx: in_data.vec_a_x, cy: in_data.vec_a_y, cz: in_data.vec_a_z,
                    radius: in_data.sphere_radius};
  assign ram_raddr = (state_r == S_NRD) ? best_idx_r : idx_r;

  rsnh_ram #(
    .WIDTH ($bits(rsnh_pkg::sphere_t)),
    .DEPTH (MAX_SPHERES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(cnt_r)),
    .wdata (ram_wd),
    .raddr (ram_raddr),
    .rdata (ram_rd)
  );

  // ---------------- arithmetic units ----------------
  logic             sq_start;
  logic             sq_done;
  logic [S_W-1:0]   sq_root;
  logic             div_start;
  logic             div_done;
  logic [DIVD_W-1:0] div_quo;
  logic [DIVD_W-1:0] div_dvd;

  // radicand taken straight from the discriminant logic in the start cycle
  rsnh_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (q_val),
    .done     (sq_done),
    .root     (sq_root)
  );

  rsnh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (rad_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------- combinational datapath ----------------
  logic [31:0]           dmag [3];
  logic [X_W-1:0]        xmag [3];
  logic signed [32:0]    ldiff [3];
  logic [H_W-1:0]        hmag;
  logic [1:0]            ax;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic                  mul_sgn;
  logic signed [H_W-1:0] pterm_h;
  logic signed [X_W-1:0] pterm_x;
  logic                  ccneg;
  logic [H_W-1:0]        ccmag;
  logic [Q_W-1:0]        cw;
  logic [Q_W-1:0]        qsum;
  logic [Q_W-1:0]        qdiff;
  disc_t                 disc;
  logic signed [H_W-1:0] t0;
  logic                  t0_pos;
  logic                  far;
  logic signed [32:0]    num;
  logic [32:0]           nmag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k]  = d_r[k][31] ? 32'(-d_r[k]) : 32'(d_r[k]);
      xmag[k]  = x_r[k][X_W-1] ? X_W'(-x_r[k]) : X_W'(x_r[k]);
    end
    ldiff[0] = 33'(o_r[0]) - 33'(ram_rd.cx);
    ldiff[1] = 33'(o_r[1]) - 33'(ram_rd.cy);
    ldiff[2] = 33'(o_r[2]) - 33'(ram_rd.cz);
    hmag = h_r[H_W-1] ? H_W'(-h_r) : H_W'(h_r);
  end

  // axis served by the current step
  always_comb begin
    if (st_r < 4'd3) begin
      ax = st_r[1:0];
    end else if (st_r < 4'd6) begin
      ax = 2'(st_r - 4'd3);
    end else begin
      ax = 2'd0;
    end
  end

  // shared 32x32 multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sgn = 1'b0;
    case (state_r)
      S_MUL1: begin
        if (st_r < 4'd3) begin
          mul_a   = dmag[ax];
          mul_b   = lmag_r[ax];
          mul_sgn = d_r[ax][31] ^ lneg_r[ax];
        end else if (st_r < 4'd6) begin
          mul_a = lmag_r[ax];
          mul_b = lmag_r[ax];
        end else if (st_r == 4'd6) begin
          mul_a = 32'(rad_r);
          mul_b = 32'(rad_r);
        end else if (st_r == 4'd7) begin
          mul_a = hmag[31:0];
          mul_b = hmag[31:0];
        end else if (st_r == 4'd8) begin
          mul_a = hmag[31:0];
          mul_b = 32'(hmag[S_W-1:32]);
        end else begin
          mul_a = 32'(hmag[S_W-1:32]);
          mul_b = 32'(hmag[S_W-1:32]);
        end
      end
      S_MUL2: begin
        if (st_r < 4'd3) begin
          mul_a   = dmag[ax];
          mul_b   = t_r;
          mul_sgn = d_r[ax][31];
        end else begin
          mul_a = xmag[ax][31:0];
          mul_b = xmag[ax][31:0];
        end
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign pterm_h = H_W'(prod_r[63:16]);
  assign pterm_x = X_W'(prod_r[63:16]);

  // quarter discriminant: h*h - c*2^16
  always_comb begin
    ccneg = cc_r[H_W-1];
    ccmag = ccneg ? H_W'(-cc_r) : H_W'(cc_r);
    cw    = Q_W'(ccmag) << 16;
    qsum  = hh_r + cw;
    qdiff = hh_r - cw;
    q_val = (ccneg || (cc_r == '0)) ? qsum : qdiff;
    if (ccneg || (cc_r == '0)) begin
      disc = (qsum != '0) ? DISC_POS : DISC_ZERO;
    end else if (hh_r < cw) begin
      disc = DISC_NEG;
    end else if (hh_r > cw) begin
      disc = DISC_POS;
    end else begin
      disc = DISC_ZERO;
    end
  end

  // near root; the far root is never smaller, so t0 <= 0 rejects the sphere
  assign t0     = -h_r - H_W'(sq_root);
  assign t0_pos = !t0[H_W-1] && (t0 != '0);

  assign far = (xmag[0] >= rsnh_pkg::AXIS_LIMIT) || (xmag[1] >= rsnh_pkg::AXIS_LIMIT) ||
               (xmag[2] >= rsnh_pkg::AXIS_LIMIT);

  assign num     = 33'(best_x_r[ax_r]) - 33'(sph_c_r[ax_r]);
  assign nmag    = num[32] ? 33'(-num) : 33'(num);
  assign div_dvd = DIVD_W'({nmag, 16'b0});

  assign sq_start  = (state_r == S_QC) && (op_r == rsnh_pkg::OP_NEAR) && (disc != DISC_NEG);
  assign div_start = (state_r == S_DST);

  // ---------------- control and datapath registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load from the done state once the result register is free or being drained
      if ((state_r == S_DONE) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.opcode;
            o_r[0]  <= in_data.vec_a_x;
            o_r[1]  <= in_data.vec_a_y;
            o_r[2]  <= in_data.vec_a_z;
            d_r[0]  <= in_data.dir_x;
            d_r[1]  <= in_data.dir_y;
            d_r[2]  <= in_data.dir_z;
            idx_r   <= '0;
            found_r <= 1'b0;
            best_r  <= rsnh_pkg::DIST_BOUND;
            res_r   <= add_res;
            case (in_data.opcode)
              rsnh_pkg::OP_ADD: begin
                if ((in_data.sphere_radius != '0) && (cnt_r < MAX_CNT)) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end
                state_r <= S_DONE;
              end
              rsnh_pkg::OP_NEAR, rsnh_pkg::OP_OCC: begin
                state_r <= (cnt_r == '0) ? S_DONE : S_RD;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_LD;
        end
        S_LD: begin
          for (int k = 0; k < 3; k++) begin
            lneg_r[k] <= ldiff[k][32];
            lmag_r[k] <= ldiff[k][32] ? 32'(-ldiff[k]) : 32'(ldiff[k]);
          end
          rad_r   <= ram_rd.radius;
          h_r     <= '0;
          cc_r    <= '0;
          st_r    <= '0;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          prod_r <= 64'(mul_a) * 64'(mul_b);
          psgn_r <= mul_sgn;
          pst_r  <= st_r;
          st_r   <= st_r + 4'd1;
          if (st_r != '0) begin
            case (pst_r)
              4'd0, 4'd1, 4'd2: h_r <= psgn_r ? h_r - pterm_h : h_r + pterm_h;
              4'd3, 4'd4, 4'd5: cc_r <= cc_r + pterm_h;
              4'd6: cc_r <= cc_r - pterm_h;
              4'd7: hh_r <= Q_W'(prod_r);
              4'd8: hh_r <= hh_r + (Q_W'(prod_r) << 33);
              default: hh_r <= hh_r + (Q_W'(prod_r) << 64);
            endcase
          end
          if (st_r == MUL1_LAST) begin
            state_r <= S_QC;
          end
        end
        S_QC: begin
          if (op_r == rsnh_pkg::OP_OCC) begin
            if (disc == DISC_POS) begin
              res_r.hit <= 1'b1;
              state_r   <= S_DONE;
            end else begin
              state_r <= S_NEXT;
            end
          end else begin
            state_r <= (disc == DISC_NEG) ? S_NEXT : S_SQ;
          end
        end
        S_SQ: begin
          if (sq_done) begin
            state_r <= S_TC;
          end
        end
        S_TC: begin
          if (t0_pos) begin
            t_r     <= (t0[H_W-1:32] != '0) ? 32'hFFFF_FFFF : t0[31:0];
            st_r    <= '0;
            dist_r  <= '0;
            state_r <= S_MUL2;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_MUL2: begin
          prod_r <= 64'(mul_a) * 64'(mul_b);
          psgn_r <= mul_sgn;
          pst_r  <= st_r;
          pax_r  <= ax;
          st_r   <= st_r + 4'd1;
          if (st_r != '0) begin
            case (pst_r)
              4'd0, 4'd1, 4'd2: begin
                x_r[pax_r] <= psgn_r ? X_W'(o_r[pax_r]) - pterm_x
                                     : X_W'(o_r[pax_r]) + pterm_x;
              end
              default: dist_r <= dist_r + DIST_W'(prod_r);
            endcase
          end
          if (st_r == MUL2_LAST) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // strict compare: on a tie the earlier sphere stays
          if (!far && (dist_r < best_r)) begin
            best_r     <= dist_r;
            best_idx_r <= idx_r;
            found_r    <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              best_x_r[k] <= 32'(x_r[k]);
            end
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (CNT_W'(idx_r) + CNT_W'(1) == cnt_r) begin
            state_r <= (op_r == rsnh_pkg::OP_NEAR && found_r) ? S_NRD : S_DONE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_RD;
          end
        end
        S_NRD: begin
          state_r <= S_NLD;
        end
        S_NLD: begin
          sph_c_r[0] <= ram_rd.cx;
          sph_c_r[1] <= ram_rd.cy;
          sph_c_r[2] <= ram_rd.cz;
          rad_r      <= ram_rd.radius;
          ax_r       <= 2'd0;
          state_r    <= S_DST;
        end
        S_DST: begin
          nneg_r  <= num[32];
          state_r <= S_DW;
        end
        S_DW: begin
          if (div_done) begin
            norm_r[ax_r] <= rsnh_pkg::sat_norm(nneg_r, div_quo);
            if (ax_r == 2'd2) begin
              state_r <= S_FIN;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= S_DST;
            end
          end
        end
        S_FIN: begin
          res_r.status    <= rsnh_pkg::ST_OK;
          res_r.hit       <= 1'b1;
          res_r.hit_x     <= best_x_r[0];
          res_r.hit_y     <= best_x_r[1];
          res_r.hit_z     <= best_x_r[2];
          res_r.normal_x  <= norm_r[0];
          res_r.normal_y  <= norm_r[1];
          res_r.normal_z  <= norm_r[2];
          res_r.sphere_id <= 6'(best_idx_r);
          state_r         <= S_DONE;
        end
        S_DONE: begin
          // hand over once the result register is free or being drained
          if (!out_valid_r || !out_stall) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RSNH_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= MAX_CNT)
  `RSNH_ASSERT(a_add_count, clk, rst_n, ram_we |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
  `RSNH_ASSERT(a_idx_in_table, clk, rst_n, (state_r == S_LD) |-> (CNT_W'(idx_r) < cnt_r))
  `RSNH_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_DONE))

endmodule
